// ===== src/bsst_pkg.sv =====
// ----------------------------------------------------------------------------
// bsst_pkg
// shared constants and controller/datapath interface types for the
// sorted-table binary search unit
// ----------------------------------------------------------------------------
package bsst_pkg;

    localparam int DEPTH_DEFAULT = 1024;

    localparam int SIZE_W  = 11;
    localparam int INDEX_W = 10;
    localparam int DATA_W  = 32;
    localparam int POS_W   = 10;

    // opcodes of an input transaction
    localparam logic OP_WRITE  = 1'b0;
    localparam logic OP_SEARCH = 1'b1;

    // commands from controller to datapath
    typedef struct packed {
        logic write_en;     // store data_value at entry_index
        logic start;        // load key and full index range
        logic init_rd;      // read both range ends
        logic cap_both;     // take both bound values from the read ports
        logic cap_low;      // take a refreshed low bound value
        logic cap_high;     // take a refreshed high bound value
        logic step_low;     // range moves above the probe
        logic step_high;    // range moves below the probe
        logic latch_found;  // hit at the probe
        logic latch_miss;   // search ends without a hit
        logic load_out;     // move the finished result to the output register
    } cmd_t;

    // status from datapath to controller
    typedef struct packed {
        logic in_range;     // range not empty and key within bound values
        logic key_eq;       // key equals the probed entry
        logic key_lt;       // key below the probed entry
    } status_t;

endpackage

// ===== src/bsst_dp.sv =====
// ----------------------------------------------------------------------------
// bsst_dp
// datapath: table memory with two registered read ports, search range,
// bound values, probe compare and result registers
// ----------------------------------------------------------------------------
module bsst_dp #(
    parameter int TABLE_DEPTH = bsst_pkg::DEPTH_DEFAULT
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  bsst_pkg::cmd_t                       cmd,
    output bsst_pkg::status_t                    status,
    input  logic [bsst_pkg::INDEX_W-1:0]         entry_index,
    input  logic signed [bsst_pkg::DATA_W-1:0]   data_value,
    input  logic                                 cfg_wr_en,
    input  logic [bsst_pkg::SIZE_W-1:0]          cfg_wr_data,
    output logic                                 found,
    output logic [bsst_pkg::POS_W-1:0]           position
);

    localparam int IDX_W = $clog2(TABLE_DEPTH);
    localparam int CNT_W = $clog2(TABLE_DEPTH + 1);
    localparam int CMP_W = (CNT_W > bsst_pkg::SIZE_W) ? CNT_W : bsst_pkg::SIZE_W;

    logic signed [bsst_pkg::DATA_W-1:0] mem [TABLE_DEPTH];

    logic [bsst_pkg::SIZE_W-1:0]        table_size_reg;
    logic [CNT_W-1:0]                   lo_reg;
    logic [CNT_W-1:0]                   hi_p1_reg;
    logic signed [bsst_pkg::DATA_W-1:0] key_reg;
    logic signed [bsst_pkg::DATA_W-1:0] bl_reg;
    logic signed [bsst_pkg::DATA_W-1:0] bh_reg;
    logic signed [bsst_pkg::DATA_W-1:0] rd_a_reg;
    logic signed [bsst_pkg::DATA_W-1:0] rd_b_reg;
    logic                               res_found_reg;
    logic [bsst_pkg::POS_W-1:0]         res_pos_reg;
    logic                               found_reg;
    logic [bsst_pkg::POS_W-1:0]         position_reg;

    logic [CMP_W-1:0]  size_sat;
    logic [CNT_W-1:0]  span;
    logic [CNT_W-1:0]  mid_ext;
    logic [IDX_W-1:0]  mid;
    logic [IDX_W-1:0]  rd_a_addr;
    logic [IDX_W-1:0]  rd_b_addr;
    logic [IDX_W-1:0]  wr_addr;
    logic              wr_ok;

    // sizes above the depth saturate
    assign size_sat = (CMP_W'(table_size_reg) > CMP_W'(TABLE_DEPTH)) ?
                      CMP_W'(TABLE_DEPTH) : CMP_W'(table_size_reg);

    // midpoint of lo .. hi_p1-1, only meaningful while the range is not empty
    assign span    = hi_p1_reg - lo_reg;
    assign mid_ext = lo_reg + ((span - CNT_W'(1)) >> 1);
    assign mid     = IDX_W'(mid_ext);

    assign rd_a_addr = cmd.init_rd ? IDX_W'(lo_reg) : mid;
    assign rd_b_addr = cmd.init_rd ? IDX_W'(hi_p1_reg - CNT_W'(1)) :
                       (status.key_lt ? IDX_W'(mid_ext - CNT_W'(1)) :
                                        IDX_W'(mid_ext + CNT_W'(1)));

    assign wr_ok   = cmd.write_en && (32'(entry_index) < 32'(TABLE_DEPTH));
    assign wr_addr = IDX_W'(entry_index);

    assign status.in_range = (lo_reg < hi_p1_reg) && (key_reg >= bl_reg) &&
                             (key_reg <= bh_reg);
    assign status.key_eq   = (key_reg == rd_a_reg);
    assign status.key_lt   = (key_reg < rd_a_reg);

    always_ff @(posedge clk)
    begin
        if (wr_ok)
        begin
            mem[wr_addr] <= data_value;
        end
        rd_a_reg <= mem[rd_a_addr];
        rd_b_reg <= mem[rd_b_addr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            table_size_reg <= '0;
        end
        else if (cfg_wr_en)
        begin
            table_size_reg <= cfg_wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.start)
        begin
            key_reg   <= data_value;
            lo_reg    <= '0;
            hi_p1_reg <= CNT_W'(size_sat);
        end
        if (cmd.step_low)
        begin
            lo_reg <= mid_ext + CNT_W'(1);
        end
        if (cmd.step_high)
        begin
            hi_p1_reg <= mid_ext;
        end
        if (cmd.cap_both)
        begin
            bl_reg <= rd_a_reg;
            bh_reg <= rd_b_reg;
        end
        if (cmd.cap_low)
        begin
            bl_reg <= rd_b_reg;
        end
        if (cmd.cap_high)
        begin
            bh_reg <= rd_b_reg;
        end
        if (cmd.latch_found)
        begin
            res_found_reg <= 1'b1;
            res_pos_reg   <= bsst_pkg::POS_W'(mid);
        end
        if (cmd.latch_miss)
        begin
            res_found_reg <= 1'b0;
            res_pos_reg   <= '0;
        end
        if (cmd.load_out)
        begin
            found_reg    <= res_found_reg;
            position_reg <= res_pos_reg;
        end
    end

    assign found    = found_reg;
    assign position = position_reg;

`ifndef SYNTHESIS
    // every halving step strictly shrinks the range
    a_range_shrinks: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.step_low || cmd.step_high) |=> (span < $past(span)))
        else $error("search range did not shrink");
`endif

endmodule

// ===== src/bsst_ctrl.sv =====
// ----------------------------------------------------------------------------
// bsst_ctrl
// controller: accepts transactions, sequences bound reads, probes and
// result hand-off
// ----------------------------------------------------------------------------
module bsst_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_stall,
    input  logic              opcode,
    output logic              out_valid,
    input  logic              out_stall,
    output bsst_pkg::cmd_t    cmd,
    input  bsst_pkg::status_t status
);

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_INIT  = 3'd1;
    localparam logic [2:0] ST_ISSUE = 3'd2;
    localparam logic [2:0] ST_EVAL  = 3'd3;
    localparam logic [2:0] ST_DONE  = 3'd4;

    // which bound value arrives on the read ports in the issue cycle
    localparam logic [1:0] REFR_BOTH = 2'd0;
    localparam logic [1:0] REFR_LOW  = 2'd1;
    localparam logic [1:0] REFR_HIGH = 2'd2;

    logic [2:0] state_reg;
    logic [2:0] state_next;
    logic [1:0] refr_reg;
    logic [1:0] refr_next;
    logic       out_valid_reg;
    logic       out_valid_next;

    assign in_stall  = (state_reg != ST_IDLE);
    assign out_valid = out_valid_reg;

    always_comb
    begin
        state_next     = state_reg;
        refr_next      = refr_reg;
        out_valid_next = out_valid_reg && out_stall;
        cmd            = '0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    if (opcode == bsst_pkg::OP_SEARCH)
                    begin
                        cmd.start  = 1'b1;
                        refr_next  = REFR_BOTH;
                        state_next = ST_INIT;
                    end
                    else
                    begin
                        cmd.write_en = 1'b1;
                    end
                end
            end
            ST_INIT:
            begin
                cmd.init_rd = 1'b1;
                state_next  = ST_ISSUE;
            end
            ST_ISSUE:
            begin
                cmd.cap_both = (refr_reg == REFR_BOTH);
                cmd.cap_low  = (refr_reg == REFR_LOW);
                cmd.cap_high = (refr_reg == REFR_HIGH);
                state_next   = ST_EVAL;
            end
            ST_EVAL:
            begin
                priority if (!status.in_range)
                begin
                    cmd.latch_miss = 1'b1;
                    state_next     = ST_DONE;
                end
                else if (status.key_eq)
                begin
                    cmd.latch_found = 1'b1;
                    state_next      = ST_DONE;
                end
                else if (status.key_lt)
                begin
                    cmd.step_high = 1'b1;
                    refr_next     = REFR_HIGH;
                    state_next    = ST_ISSUE;
                end
                else
                begin
                    cmd.step_low = 1'b1;
                    refr_next    = REFR_LOW;
                    state_next   = ST_ISSUE;
                end
            end
            ST_DONE:
            begin
                // wait for the output register to be free
                if (!out_valid_reg || !out_stall)
                begin
                    cmd.load_out   = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            refr_reg      <= REFR_BOTH;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            refr_reg      <= refr_next;
            out_valid_reg <= out_valid_next;
        end
    end

`ifndef SYNTHESIS
    a_search_starts: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall && opcode == bsst_pkg::OP_SEARCH) |=>
        (state_reg == ST_INIT))
        else $error("accepted search did not start");

    a_eval_exits: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_EVAL) |=> (state_reg == ST_ISSUE || state_reg == ST_DONE))
        else $error("probe evaluation went to a wrong state");

    a_result_from_done: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> ($past(state_reg) == ST_DONE))
        else $error("result shown without a finished search");
`endif

endmodule

// ===== src/binary_search_sorted_table_unit.sv =====
// ----------------------------------------------------------------------------
// binary_search_sorted_table_unit
// binary search over a table of signed 32-bit entries kept in ascending order
// ----------------------------------------------------------------------------
// usage
// - input channel (in_valid / in_stall): opcode OP_WRITE stores data_value at
//   entry_index (ignored when the index is not below the depth) and gives no
//   result; opcode OP_SEARCH looks for data_value as a key
// - output channel (out_valid / out_stall): one transaction per search with
//   found and position (position is zero on a miss)
// - cfg_wr_en / cfg_wr_data set the number of entries in use from index 0;
//   values above the depth saturate, zero means every search misses
// - a write does not stall, the next transaction is taken right after
// - a search with e evaluation steps (one per probe, plus one more when the
//   range runs out) raises out_valid when its result is loaded and the next
//   transaction is taken only after that; e is at most ceil(log2(size+1))+1,
//   12 for 1024 entries
// - each probe is a registered read of the midpoint entry, then the compare
//   that also issues the read of the one bound that moved
// - the output register holds one result; a finished search waits while the
//   receiver stalls a previous result, and no new transaction is taken
// - reset clears the size register and the control; table contents are
//   undefined until written
// ----------------------------------------------------------------------------
module binary_search_sorted_table_unit #(
    parameter int TABLE_DEPTH = bsst_pkg::DEPTH_DEFAULT
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    // input channel
    input  logic                                 in_valid,
    output logic                                 in_stall,
    input  logic                                 opcode,
    input  logic [bsst_pkg::INDEX_W-1:0]         entry_index,
    input  logic signed [bsst_pkg::DATA_W-1:0]   data_value,
    // output channel
    output logic                                 out_valid,
    input  logic                                 out_stall,
    output logic                                 found,
    output logic [bsst_pkg::POS_W-1:0]           position,
    // table size register
    input  logic                                 cfg_wr_en,
    input  logic [bsst_pkg::SIZE_W-1:0]          cfg_wr_data
);

    bsst_pkg::cmd_t    cmd;
    bsst_pkg::status_t status;

    // sequencing: idle, bound read, probe issue, probe evaluate, hand-off
    bsst_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .opcode    (opcode),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .cmd       (cmd),
        .status    (status)
    );

    // table memory, range registers, compares and result registers
    bsst_dp #(
        .TABLE_DEPTH (TABLE_DEPTH)
    ) u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .status      (status),
        .entry_index (entry_index),
        .data_value  (data_value),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .found       (found),
        .position    (position)
    );

endmodule

// ===== dv/tb_binary_search_sorted_table_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_binary_search_sorted_table_unit
// loads sorted tables through write transactions, fills large tables along
// each search path, sweeps the table size register and checks every search
// result against a behavioral lookup
// ----------------------------------------------------------------------------
module tb_binary_search_sorted_table_unit;

    localparam int TABLE_DEPTH   = bsst_pkg::DEPTH_DEFAULT;
    localparam int CYCLE_LIMIT   = 1000000;
    localparam int SETTLE_CYCLES = 32;       // margin above the longest search
    localparam int ITEMS_TOTAL   = 500;
    localparam int IDLE_PCT      = 37;
    localparam int QUIET_FROM    = 250;      // item window with no idling on either side
    localparam int QUIET_TO      = 350;
    localparam int HOLD_AFTER    = 40;       // results seen before the long hold-off
    localparam int HOLD_CYCLES   = 300;
    localparam logic [bsst_pkg::SIZE_W-1:0] SIZE_MAX = '1;
    localparam longint S32_MIN   = -64'sd2147483648;
    localparam logic signed [bsst_pkg::DATA_W-1:0] S32_MAX = 32'sh7FFF_FFFF;
    // full-range spacing of the values written along search paths
    localparam longint FILL_STEP = 64'd4294967296 / TABLE_DEPTH;

    // expected outcome of one search transaction
    typedef struct packed {
        logic                       hit;
        logic [bsst_pkg::POS_W-1:0] pos;
    } lookup_t;

    // ------------------------------------------------------------------------
    // scoreboard: table copy, size register copy, pending search outcomes
    // ------------------------------------------------------------------------
    class lookup_scoreboard;
        logic signed [bsst_pkg::DATA_W-1:0] entries [TABLE_DEPTH];
        bit                                 written [TABLE_DEPTH];
        logic [bsst_pkg::SIZE_W-1:0]        size_reg;
        lookup_t                            pending_lookups [$];
        int unsigned                        results_checked;
        int unsigned                        mismatches;

        function new();
            size_reg        = '0;
            results_checked = 0;
            mismatches      = 0;
        endfunction

        function void set_size(logic [bsst_pkg::SIZE_W-1:0] v);
            size_reg = v;
        endfunction

        // halve low..high until a hit, an empty range or a key outside the bounds
        function lookup_t search_outcome(logic signed [bsst_pkg::DATA_W-1:0] key);
            int      n;
            int      lo;
            int      hi;
            int      mid;
            lookup_t r;
            r  = '0;
            n  = (size_reg > TABLE_DEPTH) ? TABLE_DEPTH : int'(size_reg);
            lo = 0;
            hi = n - 1;
            while (lo <= hi && key >= entries[lo] && key <= entries[hi])
            begin
                mid = lo + (hi - lo) / 2;
                if (key < entries[mid])
                    hi = mid - 1;
                else if (key > entries[mid])
                    lo = mid + 1;
                else
                begin
                    r.hit = 1'b1;
                    r.pos = mid[bsst_pkg::POS_W-1:0];
                    break;
                end
            end
            return r;
        endfunction

        // first entry on the probe path of key that was never written, or -1
        function int first_unwritten(logic signed [bsst_pkg::DATA_W-1:0] key);
            int n;
            int lo;
            int hi;
            int mid;
            n  = (size_reg > TABLE_DEPTH) ? TABLE_DEPTH : int'(size_reg);
            lo = 0;
            hi = n - 1;
            while (lo <= hi)
            begin
                if (!written[lo])
                    return lo;
                if (key < entries[lo])
                    return -1;
                if (!written[hi])
                    return hi;
                if (key > entries[hi])
                    return -1;
                mid = lo + (hi - lo) / 2;
                if (!written[mid])
                    return mid;
                if (key < entries[mid])
                    hi = mid - 1;
                else if (key > entries[mid])
                    lo = mid + 1;
                else
                    return -1;
            end
            return -1;
        endfunction

        function void note_input(logic op, logic [bsst_pkg::INDEX_W-1:0] idx,
                                 logic signed [bsst_pkg::DATA_W-1:0] val);
            if (op == bsst_pkg::OP_WRITE)
            begin
                entries[idx] = val;
                written[idx] = 1'b1;
            end
            else
                pending_lookups.push_back(search_outcome(val));
        endfunction

        function void check_result(logic got_found, logic [bsst_pkg::POS_W-1:0] got_pos);
            lookup_t exp_r;
            results_checked++;
            if (pending_lookups.size() == 0)
            begin
                $error("result with no search pending: found=%0b position=%0d",
                       got_found, got_pos);
                mismatches++;
                return;
            end
            exp_r = pending_lookups.pop_front();
            if (got_found !== exp_r.hit)
            begin
                $error("found: expected %0b, actual %0b", exp_r.hit, got_found);
                mismatches++;
            end
            if (got_pos !== exp_r.pos)
            begin
                $error("position: expected %0d, actual %0d", exp_r.pos, got_pos);
                mismatches++;
            end
        endfunction
    endclass

    // ------------------------------------------------------------------------
    // clock, dut signals
    // ------------------------------------------------------------------------
    logic clk = 1'b0;
    logic rst_n = 1'b0;

    logic                               in_valid    = 1'b0;
    logic                               in_stall;
    logic                               opcode      = bsst_pkg::OP_WRITE;
    logic [bsst_pkg::INDEX_W-1:0]       entry_index = '0;
    logic signed [bsst_pkg::DATA_W-1:0] data_value  = '0;
    logic                               out_valid;
    logic                               out_stall   = 1'b0;
    logic                               found;
    logic [bsst_pkg::POS_W-1:0]         position;
    logic                               cfg_wr_en   = 1'b0;
    logic [bsst_pkg::SIZE_W-1:0]        cfg_wr_data = '0;

    int   cycle_count = 0;
    int   items_sent  = 0;
    logic quiet;
    lookup_scoreboard board;

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    binary_search_sorted_table_unit #(
        .TABLE_DEPTH(TABLE_DEPTH)
    ) i_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .opcode      (opcode),
        .entry_index (entry_index),
        .data_value  (data_value),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .found       (found),
        .position    (position),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data)
    );

    // idling is switched off on both sides inside the quiet window
    assign quiet = (items_sent >= QUIET_FROM) && (items_sent < QUIET_TO);

    // run limit, far above the slowest correct run
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("FAILURE");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // receiver: check each accepted result, stall at random, and once hold
    // off for a long stretch so results back up and the input stalls
    // ------------------------------------------------------------------------
    int hold_left = 0;
    bit hold_done = 1'b0;

    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
            board.check_result(found, position);
        if (hold_left > 0)
        begin
            hold_left <= hold_left - 1;
            out_stall <= 1'b1;
        end
        else if (!hold_done && board.results_checked >= HOLD_AFTER)
        begin
            hold_done <= 1'b1;
            hold_left <= HOLD_CYCLES;
            out_stall <= 1'b1;
        end
        else
            out_stall <= !quiet && ($urandom_range(0, 99) < IDLE_PCT);
    end

    // ------------------------------------------------------------------------
    // sender tasks
    // ------------------------------------------------------------------------
    function automatic bit idle_roll();
        return !quiet && ($urandom_range(0, 99) < IDLE_PCT);
    endfunction

    // ascending value for entry i, spread over the whole signed range
    function automatic logic signed [bsst_pkg::DATA_W-1:0] fill_value(input int i);
        longint v;
        v = S32_MIN + longint'(i) * FILL_STEP + FILL_STEP / 2;
        return v[bsst_pkg::DATA_W-1:0];
    endfunction

    // offer one transaction, hold it while stalled, note it once accepted
    task automatic send_item(input logic op, input logic [bsst_pkg::INDEX_W-1:0] idx,
                             input logic signed [bsst_pkg::DATA_W-1:0] val);
        while (idle_roll())
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid    <= 1'b1;
        opcode      <= op;
        entry_index <= idx;
        data_value  <= val;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        board.note_input(op, idx, val);
        items_sent++;
    endtask

    task automatic send_write(input logic [bsst_pkg::INDEX_W-1:0] idx,
                              input logic signed [bsst_pkg::DATA_W-1:0] val);
        send_item(bsst_pkg::OP_WRITE, idx, val);
    endtask

    // entry_index is don't-care on a search, so it gets random bits
    task automatic send_search(input logic signed [bsst_pkg::DATA_W-1:0] key);
        logic [bsst_pkg::INDEX_W-1:0] junk_idx;
        junk_idx = bsst_pkg::INDEX_W'($urandom);
        send_item(bsst_pkg::OP_SEARCH, junk_idx, key);
    endtask

    // write every entry that the search of key would read before it is known,
    // so no search ever probes an unwritten entry
    task automatic send_search_filled(input logic signed [bsst_pkg::DATA_W-1:0] key);
        int u;
        u = board.first_unwritten(key);
        while (u >= 0)
        begin
            send_write(bsst_pkg::INDEX_W'(u), fill_value(u));
            u = board.first_unwritten(key);
        end
        send_search(key);
    endtask

    // size register is only written with the block drained and quiet
    task automatic set_table_size(input logic [bsst_pkg::SIZE_W-1:0] v);
        in_valid <= 1'b0;
        while (board.pending_lookups.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= v;
        @(posedge clk);
        cfg_wr_en <= 1'b0;
        board.set_size(v);
    endtask

    // fresh ascending values in entries 0..n-1, sparse or dense at random
    task automatic load_sorted(input int n);
        longint v;
        longint gap_max;
        longint span;
        gap_max = ($urandom_range(0, 3) == 0) ? 3 : 4194304;
        span    = 64'hFFFF_FFFF - longint'(n) * gap_max;
        v       = S32_MIN + longint'($urandom_range(0, span[31:0]));
        for (int i = 0; i < n; i++)
        begin
            send_write(i[bsst_pkg::INDEX_W-1:0], v[bsst_pkg::DATA_W-1:0]);
            v = v + $urandom_range(1, gap_max[31:0]);
        end
    endtask

    // mostly searches for stored keys, plus near misses, random keys and writes
    task automatic run_phase(input int eff_n, input int count);
        int pick;
        int idx;
        logic signed [bsst_pkg::DATA_W-1:0] key;
        logic signed [bsst_pkg::DATA_W-1:0] val;
        for (int k = 0; k < count; k++)
        begin
            pick = $urandom_range(0, 99);
            idx  = (eff_n > 0) ? $urandom_range(0, eff_n - 1) : 0;
            if (pick < 85)
            begin
                if (eff_n == 0 || pick >= 75)
                    key = $urandom;
                else if (pick < 60)
                    key = board.entries[idx];
                else
                    key = board.entries[idx] + (pick[0] ? 1 : -1);
                send_search(key);
            end
            else if (pick < 93 && eff_n < TABLE_DEPTH)
            begin
                // outside the range in use, no effect on searches
                val = $urandom;
                send_write(bsst_pkg::INDEX_W'($urandom_range(eff_n, TABLE_DEPTH - 1)),
                           val);
            end
            else
            begin
                // rewrite in range: same value keeps order, random may break it
                val = pick[0] ? board.entries[idx] : $urandom;
                send_write(idx[bsst_pkg::INDEX_W-1:0], val);
            end
        end
    endtask

    // ------------------------------------------------------------------------
    // main sequence
    // ------------------------------------------------------------------------
    initial
    begin
        int r;
        int eff_n;
        int count;
        logic [bsst_pkg::SIZE_W-1:0] sz;
        board = new();
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        // empty table misses whatever the entries hold
        set_table_size('0);
        send_search('0);
        send_search(S32_MAX);

        // oversized size saturates to the full depth
        set_table_size(SIZE_MAX);
        send_search_filled(fill_value(0));
        send_search_filled(fill_value(TABLE_DEPTH - 1));
        send_search_filled(fill_value(TABLE_DEPTH / 2));
        send_search_filled(fill_value(700));
        send_search_filled(fill_value(1) + 1);
        send_search_filled(S32_MAX);
        set_table_size(bsst_pkg::SIZE_W'(TABLE_DEPTH));
        send_search_filled(fill_value(TABLE_DEPTH - 1));
        send_search_filled(fill_value(TABLE_DEPTH / 2 - 1));
        send_search_filled(fill_value(300) - 1);
        set_table_size(bsst_pkg::SIZE_W'(700));
        send_search_filled(fill_value(699));
        send_search_filled(fill_value(699) + 1);

        // single entry: hit, and a key just above it
        set_table_size(bsst_pkg::SIZE_W'(1));
        send_search(board.entries[0]);
        send_search(board.entries[0] + 1);

        // three entries: key below, key above, each position, and a gap
        send_write(bsst_pkg::INDEX_W'(0), -5);
        send_write(bsst_pkg::INDEX_W'(1), 0);
        send_write(bsst_pkg::INDEX_W'(2), 7);
        set_table_size(bsst_pkg::SIZE_W'(3));
        send_search(-6);
        send_search(8);
        send_search(-5);
        send_search(0);
        send_search(7);
        send_search(3);
        // middle entry now above the top one, the probe order decides
        send_write(bsst_pkg::INDEX_W'(1), 100);
        send_search(7);
        send_search(100);

        // random phases, each with its own size setting and, unless the size is zero, a freshly loaded table
        while (items_sent < ITEMS_TOTAL)
        begin
            r = $urandom_range(0, 99);
            if (r < 8)
                sz = '0;
            else
                sz = bsst_pkg::SIZE_W'($urandom_range(1, 64));
            eff_n = int'(sz);
            set_table_size(sz);
            if (eff_n >= 1)
                load_sorted(eff_n);
            count = $urandom_range(10, 40);
            run_phase(eff_n, count);
        end

        // drain, then give a stray result time to show up
        in_valid <= 1'b0;
        while (board.pending_lookups.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (board.mismatches == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
